// ===== src/cti_pkg.sv =====
// Shared types and constants for the calibration table interpolator.
package cti_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_TABLE_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_EMPTY_THRESHOLD = 3'd1;
  localparam logic [2:0] CFG_FRAC_SHIFT      = 3'd2;
  localparam logic [2:0] CFG_GAIN            = 3'd3;
  localparam logic [2:0] CFG_POINT_COUNT     = 3'd4;

  // Input kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_CONVERT = 1'b1;

  // Result path codes
  typedef enum logic [2:0] {
    PATH_RAW    = 3'd0,
    PATH_EMPTY  = 3'd1,
    PATH_TOP    = 3'd2,
    PATH_BOTTOM = 3'd3,
    PATH_INTERP = 3'd4,
    PATH_SAT    = 3'd5
  } path_e;

  // Item class decided by the front end
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_RAW   = 2'd1,
    OP_EMPTY = 2'd2,
    OP_TABLE = 2'd3
  } op_e;

  // Queue entry: reading carries the scaled sample for table conversions,
  // value carries the pass-through level for raw conversions
  typedef struct packed {
    op_e         op;
    logic [4:0]  index;
    logic [30:0] reading;
    logic [31:0] value;
  } entry_t;

  // One table point
  typedef struct packed {
    logic [30:0] reading;
    logic [31:0] value;
  } point_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    B_IDLE,
    B_FETCH,
    B_CHECK,
    B_MULLO,
    B_MULHI,
    B_DINIT,
    B_DIV,
    B_SUM,
    B_SCALE,
    B_SHIFT,
    B_OUT
  } bstate_e;

endpackage

// ===== src/cti_front.sv =====
// Front end: accepts input items and classifies them into queue entries.
module cti_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [4:0]         point_index_i,
  input  logic [30:0]        point_reading_i,
  input  logic [31:0]        point_value_i,
  input  logic [15:0]        raw_sample_i,
  input  logic               table_enable_i,
  input  logic [15:0]        empty_threshold_i,
  input  logic [3:0]         frac_shift_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output cti_pkg::entry_t    q_data_o
);
  import cti_pkg::*;

  // Transfer happens whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the item
  always_comb begin
    q_data_o.index   = point_index_i;
    q_data_o.reading = point_reading_i;
    q_data_o.value   = point_value_i;
    if (kind_i == KIND_LOAD) begin
      q_data_o.op = OP_LOAD;
    end else if (!table_enable_i) begin
      q_data_o.op    = OP_RAW;
      q_data_o.value = {16'h0000, raw_sample_i};
    end else if (raw_sample_i >= empty_threshold_i) begin
      q_data_o.op    = OP_EMPTY;
      q_data_o.value = 32'h0;
    end else begin
      q_data_o.op      = OP_TABLE;
      q_data_o.reading = 31'(raw_sample_i) << frac_shift_i;
    end
  end

endmodule

// ===== src/cti_fifo.sv =====
// Two-entry queue between the front end and the back end.
module cti_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cti_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cti_pkg::entry_t head_o
);
  import cti_pkg::*;

  entry_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

// ===== src/cti_back.sv =====
// Back end: table memory, point search, interpolation divider and scaling.
module cti_back #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  cti_pkg::entry_t q_head_i,
  output logic            q_pop_o,
  input  logic [3:0]      frac_shift_i,
  input  logic [15:0]     gain_i,
  input  logic [5:0]      point_count_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     level_o,
  output logic [2:0]      path_o
);
  import cti_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);

  bstate_e     state_q, state_d;
  point_t      mem_q [TABLE_DEPTH];
  point_t      rd_q;
  logic        mem_we;
  logic        out_load;

  entry_t      ent_q;
  logic [IW-1:0] idx_q, last_idx;
  logic [30:0] xa_q, p_q, d_q;
  logic [31:0] ya_q, mag_q, rem_q, quo_q, yv_q, res_level_q;
  logic        neg_q;
  logic [62:0] pp_q;
  logic [4:0]  cnt_q;
  logic signed [47:0] scaled_q;
  path_e       res_path_q;
  logic        out_valid_q;
  logic [31:0] level_q;
  logic [2:0]  path_q;

  logic        load_ok, hit_top, hit_int, at_last;
  logic signed [32:0] dyn;
  logic [31:0] trial;
  logic signed [32:0] ysum;
  logic signed [47:0] shifted;
  logic [15:0] mul_half;
  logic [46:0] part_prod;

  // Effective last point index
  always_comb begin
    if (point_count_i == 6'd0) begin
      last_idx = '0;
    end else if (32'(point_count_i) > TABLE_DEPTH) begin
      last_idx = IW'(TABLE_DEPTH - 1);
    end else begin
      last_idx = IW'(point_count_i - 6'd1);
    end
  end

  // Search decisions on the point just read
  assign load_ok = 32'(q_head_i.index) < TABLE_DEPTH;
  assign hit_top = (idx_q == '0) && (ent_q.reading >= rd_q.reading);
  assign hit_int = (idx_q != '0) && (ent_q.reading <= xa_q) &&
                   (ent_q.reading >= rd_q.reading);
  assign at_last = idx_q == last_idx;
  assign dyn     = {ya_q[31], ya_q} - {rd_q.value[31], rd_q.value};
  assign trial   = {rem_q[30:0], quo_q[31]};
  assign ysum    = neg_q ? ({ya_q[31], ya_q} + {1'b0, quo_q})
                         : ({ya_q[31], ya_q} - {1'b0, quo_q});
  assign shifted = scaled_q >>> frac_shift_i;

  // Shared 16x31 multiplier, low half then high half of the slope magnitude
  assign mul_half  = (state_q == B_MULLO) ? mag_q[15:0] : mag_q[31:16];
  assign part_prod = 47'(mul_half) * 47'(p_q);

  // Table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[IW'(q_head_i.index)] <= {q_head_i.reading, q_head_i.value};
    end
    rd_q <= mem_q[idx_q];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          case (q_head_i.op)
            OP_LOAD:  state_d = B_IDLE;
            OP_TABLE: state_d = B_FETCH;
            default:  state_d = B_OUT;
          endcase
        end
      end
      B_FETCH: state_d = B_CHECK;
      B_CHECK: begin
        if (hit_top) state_d = B_OUT;
        else if (hit_int) state_d = (xa_q == rd_q.reading) ? B_SCALE : B_MULLO;
        else if (at_last) state_d = B_SCALE;
        else state_d = B_FETCH;
      end
      B_MULLO: state_d = B_MULHI;
      B_MULHI: state_d = B_DINIT;
      B_DINIT: state_d = B_DIV;
      B_DIV:   state_d = (cnt_q == 5'd31) ? B_SUM : B_DIV;
      B_SUM:   state_d = B_SCALE;
      B_SCALE: state_d = B_SHIFT;
      B_SHIFT: state_d = B_OUT;
      B_OUT:   state_d = (!out_valid_q || out_ready_i) ? B_IDLE : B_OUT;
      default: state_d = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      B_IDLE: begin
        q_pop_o = q_valid_i;
        mem_we  = q_valid_i && (q_head_i.op == OP_LOAD) && load_ok;
      end
      B_OUT:   out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        ent_q <= q_head_i;
        idx_q <= '0;
        res_level_q <= q_head_i.value;
        res_path_q  <= (q_head_i.op == OP_RAW) ? PATH_RAW : PATH_EMPTY;
      end
      B_CHECK: begin
        if (hit_top) begin
          res_level_q <= 32'(gain_i >> frac_shift_i);
          res_path_q  <= PATH_TOP;
        end else if (hit_int) begin
          p_q        <= xa_q - ent_q.reading;
          d_q        <= xa_q - rd_q.reading;
          neg_q      <= dyn[32];
          mag_q      <= dyn[32] ? 32'(-dyn) : dyn[31:0];
          yv_q       <= ya_q;
          res_path_q <= PATH_INTERP;
        end else if (at_last) begin
          yv_q       <= rd_q.value;
          res_path_q <= PATH_BOTTOM;
        end else begin
          xa_q  <= rd_q.reading;
          ya_q  <= rd_q.value;
          idx_q <= idx_q + IW'(1);
        end
      end
      B_MULLO: pp_q <= 63'(part_prod);
      B_MULHI: pp_q <= pp_q + (63'(part_prod) << 16);
      B_DINIT: begin
        rem_q <= {1'b0, pp_q[62:32]};
        quo_q <= pp_q[31:0];
        cnt_q <= 5'd0;
      end
      B_DIV: begin
        if (trial >= {1'b0, d_q}) begin
          rem_q <= trial - {1'b0, d_q};
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= trial;
          quo_q <= {quo_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q + 5'd1;
      end
      B_SUM:   yv_q <= ysum[31:0];
      B_SCALE: scaled_q <= $signed(yv_q) * $signed({1'b0, gain_i});
      B_SHIFT: begin
        if (shifted > $signed(48'h0000_7FFF_FFFF)) begin
          res_level_q <= 32'h7FFF_FFFF;
          res_path_q  <= PATH_SAT;
        end else if (shifted < $signed(48'hFFFF_8000_0000)) begin
          res_level_q <= 32'h8000_0000;
          res_path_q  <= PATH_SAT;
        end else begin
          res_level_q <= shifted[31:0];
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      level_q <= res_level_q;
      path_q  <= res_path_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign path_o      = path_q;

  // Checks
  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == B_IDLE && q_valid_i))
    else $error("table write outside idle");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> d_q != 31'd0)
    else $error("divide by zero-width interval");
  a_check_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_CHECK |-> $past(state_q) == B_FETCH)
    else $error("check without fetch");

endmodule

// ===== src/calibration_table_interpolator_unit.sv =====
// Top level of the calibration table interpolator.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------
//  input    | in_valid_i/in_ready_o | kind, point_index/reading/value, raw
//  output   | out_valid_o/out_ready_i | level_o, path_o
//  config   | cfg_we_i              | cfg_index_i, cfg_data_i
//
// A load item finishes in idle; raw and empty conversions go straight to output.
// A table conversion fetches and checks each point (one memory read port), then
// interpolates through multiply, 32-step serial divider, sum, scale and shift.
// The front queue holds two items, so input transfers continue while the back
// end works or a result waits. No clearing pass after reset; table is undefined.
module calibration_table_interpolator_unit #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [4:0]  point_index_i,
  input  logic [30:0] point_reading_i,
  input  logic [31:0] point_value_i,
  input  logic [15:0] raw_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] level_o,
  output logic [2:0]  path_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import cti_pkg::*;

  logic        table_enable_q;
  logic [15:0] empty_threshold_q;
  logic [3:0]  frac_shift_q;
  logic [15:0] gain_q;
  logic [5:0]  point_count_q;

  logic   q_full, q_push, q_pop, q_valid;
  entry_t q_in, q_head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_enable_q    <= 1'b0;
      empty_threshold_q <= 16'hFFFF;
      frac_shift_q      <= 4'd0;
      gain_q            <= 16'd1;
      point_count_q     <= 6'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TABLE_ENABLE:    table_enable_q    <= cfg_data_i[0];
        CFG_EMPTY_THRESHOLD: empty_threshold_q <= cfg_data_i;
        CFG_FRAC_SHIFT:      frac_shift_q      <= cfg_data_i[3:0];
        CFG_GAIN:            gain_q            <= cfg_data_i;
        CFG_POINT_COUNT:     point_count_q     <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  cti_front u_front (
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .point_index_i     (point_index_i),
    .point_reading_i   (point_reading_i),
    .point_value_i     (point_value_i),
    .raw_sample_i      (raw_sample_i),
    .table_enable_i    (table_enable_q),
    .empty_threshold_i (empty_threshold_q),
    .frac_shift_i      (frac_shift_q),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_data_o          (q_in)
  );

  cti_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  cti_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .frac_shift_i  (frac_shift_q),
    .gain_i        (gain_q),
    .point_count_i (point_count_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .level_o       (level_o),
    .path_o        (path_o)
  );

endmodule
